### src/decayed_score_top_n_select_defines.svh
// Assertion macros used by the checker file.
`ifndef DECAYED_SCORE_TOP_N_SELECT_DEFINES_SVH
`define DECAYED_SCORE_TOP_N_SELECT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DSTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dsts check failed");

// Next-cycle implication, checked outside reset.
`define DSTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dsts check failed");

`endif

### src/dsts_pkg.sv
// Types and constants of the decayed score top-N selector.
`default_nettype none
package dsts_pkg;
  localparam int unsigned MaxKeep   = 16;
  localparam int unsigned KeepW     = $clog2(MaxKeep + 1);
  localparam int unsigned RankW     = 4;
  localparam int unsigned IdW       = 31;
  localparam int unsigned CntW      = 31;
  localparam int unsigned TimeW     = 40;
  localparam int unsigned ScoreW    = 64;
  localparam int unsigned RawW      = 37;
  localparam int unsigned DenW      = 41;
  localparam int unsigned NumW      = 64;
  localparam int unsigned DivCntW   = $clog2(NumW);
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [TimeW-1:0] MinAge     = TimeW'(3600);
  localparam logic [DenW-1:0]  AgeOffset  = DenW'(7200);
  localparam logic [KeepW-1:0] KeepReset  = KeepW'(10);

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegNowTime  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegTopCount = CfgIdxW'(1);

  typedef enum logic [1:0] {
    DivIdle,
    DivPrep,
    DivMul,
    DivRun
  } div_state_e;

  typedef enum logic [1:0] {
    TopIdle,
    TopScore,
    TopInsert,
    TopEmit
  } top_state_e;

  // Contents of one cell of the sorted chain
  typedef struct packed {
    logic              valid;
    logic [ScoreW-1:0] score;
    logic [IdW-1:0]    id;
  } slot_t;

  // Commands broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;
endpackage
`default_nettype wire

### src/dsts_score_div.sv
// Score unit: weighted sum, scale, then bit-serial restoring division.
`default_nettype none
module dsts_score_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [dsts_pkg::CntW-1:0]   like_count_i,
  input  wire logic [dsts_pkg::CntW-1:0]   view_count_i,
  input  wire logic [dsts_pkg::CntW-1:0]   comment_total_i,
  input  wire logic [dsts_pkg::TimeW-1:0]  created_time_i,
  input  wire logic [dsts_pkg::TimeW-1:0]  now_time_i,
  output logic                             done_o,
  output logic [dsts_pkg::ScoreW-1:0]      score_o
);
  dsts_pkg::div_state_e state_q, state_d;
  logic [dsts_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [dsts_pkg::RawW-1:0]    raw_q, raw_d;
  logic [dsts_pkg::DenW-1:0]    den_q, den_d;
  logic [dsts_pkg::NumW-1:0]    num_q, num_d;
  logic [dsts_pkg::DenW-1:0]    rem_q, rem_d;
  logic [dsts_pkg::TimeW-1:0]   age;
  logic [dsts_pkg::DenW:0]      rem_sh;
  logic [dsts_pkg::RawW+9:0]    scaled;

  // age clipped at zero and raised to one hour
  always_comb begin
    age = (now_time_i > created_time_i) ? (now_time_i - created_time_i) : '0;
    if (age < dsts_pkg::MinAge) age = dsts_pkg::MinAge;
  end

  assign scaled = (dsts_pkg::RawW+10)'(raw_q) * (dsts_pkg::RawW+10)'(720);
  assign rem_sh = {rem_q, num_q[dsts_pkg::NumW-1]};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dsts_pkg::DivIdle: if (start_i) state_d = dsts_pkg::DivPrep;
      dsts_pkg::DivPrep: state_d = dsts_pkg::DivMul;
      dsts_pkg::DivMul:  state_d = dsts_pkg::DivRun;
      dsts_pkg::DivRun:  if (cnt_q == '1) state_d = dsts_pkg::DivIdle;
      default:           state_d = dsts_pkg::DivIdle;
    endcase
  end

  // datapath; quotient bits shift into the low end of the numerator
  always_comb begin
    raw_d = raw_q;
    den_d = den_q;
    num_d = num_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    done_o = 1'b0;
    case (state_q)
      dsts_pkg::DivPrep: begin
        raw_d = dsts_pkg::RawW'(30) * dsts_pkg::RawW'(like_count_i)
              + dsts_pkg::RawW'(10) * dsts_pkg::RawW'(view_count_i)
              + dsts_pkg::RawW'(20) * dsts_pkg::RawW'(comment_total_i);
        den_d = dsts_pkg::DenW'(age) + dsts_pkg::AgeOffset;
      end
      dsts_pkg::DivMul: begin
        num_d = {1'b0, scaled, 16'd0};
        rem_d = '0;
        cnt_d = '0;
      end
      dsts_pkg::DivRun: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = dsts_pkg::DenW'(rem_sh - {1'b0, den_q});
          num_d = {num_q[dsts_pkg::NumW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[dsts_pkg::DenW-1:0];
          num_d = {num_q[dsts_pkg::NumW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        done_o = (cnt_q == '1);
      end
      default: ;
    endcase
  end

  assign score_o = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsts_pkg::DivIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_d;
    den_q <= den_d;
    num_q <= num_d;
    rem_q <= rem_d;
  end
endmodule
`default_nettype wire

### src/dsts_cell.sv
// One cell of the sorted chain: holds a record, takes from neighbors.
`default_nettype none
module dsts_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire dsts_pkg::cell_ctrl_t         ctrl_i,
  input  wire dsts_pkg::slot_t              new_i,
  input  wire dsts_pkg::slot_t              prev_i,
  input  wire logic                         prev_beat_i,
  input  wire dsts_pkg::slot_t              next_i,
  output dsts_pkg::slot_t                   slot_o,
  output logic                              beat_o
);
  dsts_pkg::slot_t slot_q, slot_d;

  // the new record goes ahead of this one (ties keep the older record)
  assign beat_o = !slot_q.valid || (slot_q.score < new_i.score);

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.clear) begin
      slot_d.valid = 1'b0;
    end else if (ctrl_i.insert) begin
      if (prev_beat_i) slot_d = prev_i;
      else if (beat_o) slot_d = new_i;
    end else if (ctrl_i.shift) begin
      slot_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
endmodule
`default_nettype wire

### src/decayed_score_top_n_select.sv
// Top level: config registers, control sequencer, score unit and cell chain.
//
//  channel | signals                               | direction
//  cfg     | cfg_valid_i/ready_o, index, data      | in
//  in      | in_valid_i/ready_o, record fields     | in
//  out     | out_valid_o/ready_i, id, rank, end    | out
//
// One record passes through accept, the setup states DivPrep and DivMul of the score unit,
// 64 steps of its one-bit-per-cycle divider, and one chain insert.
// A final record then shows one result per cycle while out_ready_i is high.
// Stalls on the output hold the chain; no record is taken while results wait.
// Reset empties the chain at once, top_count reads 10 and now_time 0.
`default_nettype none
module decayed_score_top_n_select (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dsts_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dsts_pkg::TimeW-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dsts_pkg::IdW-1:0]      record_id_i,
  input  wire logic [dsts_pkg::CntW-1:0]     like_count_i,
  input  wire logic [dsts_pkg::CntW-1:0]     view_count_i,
  input  wire logic [dsts_pkg::CntW-1:0]     comment_total_i,
  input  wire logic [dsts_pkg::TimeW-1:0]    created_time_i,
  input  wire logic                          final_record_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [dsts_pkg::IdW-1:0]           best_id_o,
  output logic [dsts_pkg::RankW-1:0]         rank_o,
  output logic                               run_end_o
);
  dsts_pkg::top_state_e state_q, state_d;
  logic [dsts_pkg::TimeW-1:0]  now_time_q;
  logic [dsts_pkg::KeepW-1:0]  top_count_q;
  logic [dsts_pkg::IdW-1:0]    id_q;
  logic                        final_q;
  logic [dsts_pkg::CntW-1:0]   like_q, view_q, comm_q;
  logic [dsts_pkg::TimeW-1:0]  created_q;
  logic [dsts_pkg::RankW-1:0]  rank_q, rank_d;
  logic [dsts_pkg::KeepW-1:0]  keep;
  logic                        in_acc, out_acc, div_start, div_done;
  logic [dsts_pkg::ScoreW-1:0] score;
  dsts_pkg::cell_ctrl_t        ctrl;
  dsts_pkg::slot_t             new_slot;
  dsts_pkg::slot_t             slots [dsts_pkg::MaxKeep];
  logic [dsts_pkg::MaxKeep-1:0] beats;

  assign cfg_ready_o = 1'b1;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_time_q  <= '0;
      top_count_q <= dsts_pkg::KeepReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dsts_pkg::RegNowTime:  now_time_q  <= cfg_data_i;
        dsts_pkg::RegTopCount: top_count_q <= cfg_data_i[dsts_pkg::KeepW-1:0];
        default: ;
      endcase
    end
  end

  // record held while it is scored
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      id_q      <= record_id_i;
      final_q   <= final_record_i;
      like_q    <= like_count_i;
      view_q    <= view_count_i;
      comm_q    <= comment_total_i;
      created_q <= created_time_i;
    end
  end

  dsts_score_div u_score (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (div_start),
    .like_count_i    (like_q),
    .view_count_i    (view_q),
    .comment_total_i (comm_q),
    .created_time_i  (created_q),
    .now_time_i      (now_time_q),
    .done_o          (div_done),
    .score_o         (score)
  );

  // report count limited to one .. MaxKeep
  always_comb begin
    keep = top_count_q;
    if (keep == '0) keep = dsts_pkg::KeepW'(1);
    if (keep > dsts_pkg::KeepW'(dsts_pkg::MaxKeep)) keep = dsts_pkg::KeepW'(dsts_pkg::MaxKeep);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dsts_pkg::TopIdle:   if (in_acc) state_d = dsts_pkg::TopScore;
      dsts_pkg::TopScore:  if (div_done) state_d = dsts_pkg::TopInsert;
      dsts_pkg::TopInsert: state_d = final_q ? dsts_pkg::TopEmit : dsts_pkg::TopIdle;
      dsts_pkg::TopEmit:   if (out_acc && run_end_o) state_d = dsts_pkg::TopIdle;
      default:             state_d = dsts_pkg::TopIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o  = 1'b0;
    div_start   = 1'b0;
    out_valid_o = 1'b0;
    ctrl        = '0;
    rank_d      = rank_q;
    case (state_q)
      dsts_pkg::TopIdle: begin
        in_ready_o = 1'b1;
        div_start  = in_valid_i;
        rank_d     = '0;
      end
      dsts_pkg::TopInsert: ctrl.insert = 1'b1;
      dsts_pkg::TopEmit: begin
        out_valid_o = 1'b1;
        if (out_acc) begin
          ctrl.shift  = !run_end_o;
          ctrl.clear  = run_end_o;
          rank_d      = rank_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign best_id_o = slots[0].id;
  assign rank_o    = rank_q;
  assign run_end_o = (({1'b0, rank_q} + 1'b1) == keep) || !slots[1].valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsts_pkg::TopIdle;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
    end
  end

  assign new_slot = '{valid: 1'b1, score: score, id: id_q};

  // sorted chain, best record in cell 0
  for (genvar i = 0; i < dsts_pkg::MaxKeep; i++) begin : g_cell
    dsts_pkg::slot_t prev_s, next_s;
    logic            prev_b;
    if (i == 0) begin : g_head
      assign prev_s = new_slot;
      assign prev_b = 1'b0;
    end else begin : g_body
      assign prev_s = slots[i-1];
      assign prev_b = beats[i-1];
    end
    if (i == dsts_pkg::MaxKeep - 1) begin : g_tail
      assign next_s = '0;
    end else begin : g_mid
      assign next_s = slots[i+1];
    end
    dsts_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_i       (new_slot),
      .prev_i      (prev_s),
      .prev_beat_i (prev_b),
      .next_i      (next_s),
      .slot_o      (slots[i]),
      .beat_o      (beats[i])
    );
  end
endmodule
`default_nettype wire

### src/dsts_checker.sv
// Port-level checks of the top-N selector, bound to the top level.
`default_nettype none
`include "decayed_score_top_n_select_defines.svh"
module dsts_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [dsts_pkg::IdW-1:0]     best_id_o,
  input wire logic [dsts_pkg::RankW-1:0]   rank_o,
  input wire logic                         run_end_o
);
  // a stalled result holds
  `DSTS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(best_id_o))
  // one record at a time
  `DSTS_ASSERT_NEXT(a_busy, in_valid_i && in_ready_o, !in_ready_o)
  // no record taken while results are pending
  `DSTS_ASSERT_NOW(a_excl, out_valid_o, !in_ready_o)
  // the run closes after its last rank
  `DSTS_ASSERT_NEXT(a_end, out_valid_o && out_ready_i && run_end_o, !out_valid_o)
  // ranks count up within a run
  `DSTS_ASSERT_NEXT(a_rank, out_valid_o && out_ready_i && !run_end_o,
                    out_valid_o && (rank_o == $past(rank_o) + 1'b1))
endmodule

bind decayed_score_top_n_select dsts_checker u_dsts_checker (.*);
`default_nettype wire

### tb/decayed_score_top_n_select_test.sv
// Self-checking testbench of the decayed score top-N selector.
`timescale 1ns / 1ps
module decayed_score_top_n_select_test;
  localparam int IdleLimit = 3000;
  localparam int SettleCycles = 80;
  localparam int LongHold = 400;
  // indexes outside the register list
  localparam logic [dsts_pkg::CfgIdxW-1:0] RegSpareLo = dsts_pkg::CfgIdxW'(2);
  localparam logic [dsts_pkg::CfgIdxW-1:0] RegSpareHi = dsts_pkg::CfgIdxW'(3);

  // One input record
  typedef struct {
    logic [dsts_pkg::IdW-1:0]   id;
    logic [dsts_pkg::CntW-1:0]  likes;
    logic [dsts_pkg::CntW-1:0]  views;
    logic [dsts_pkg::CntW-1:0]  cmts;
    logic [dsts_pkg::TimeW-1:0] created;
    logic                       fin;
    logic                       typed;
    logic [dsts_pkg::IdW-1:0]   typed_id;
  } record_t;

  // One reported rank
  typedef struct {
    logic [dsts_pkg::IdW-1:0]   id;
    logic [dsts_pkg::RankW-1:0] rank;
    logic                       last;
  } rank_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [dsts_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [dsts_pkg::TimeW-1:0]    cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [dsts_pkg::IdW-1:0]      record_id_i = '0;
  logic [dsts_pkg::CntW-1:0]     like_count_i = '0;
  logic [dsts_pkg::CntW-1:0]     view_count_i = '0;
  logic [dsts_pkg::CntW-1:0]     comment_total_i = '0;
  logic [dsts_pkg::TimeW-1:0]    created_time_i = '0;
  logic                          final_record_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [dsts_pkg::IdW-1:0]      best_id_o;
  logic [dsts_pkg::RankW-1:0]    rank_o;
  logic                          run_end_o;

  decayed_score_top_n_select uut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: registers and the sorted store
  logic [dsts_pkg::TimeW-1:0] now_reg;
  logic [4:0]                 top_reg;
  logic [63:0]                kept_score [dsts_pkg::MaxKeep];
  logic [dsts_pkg::IdW-1:0]   kept_id    [dsts_pkg::MaxKeep];
  logic                       kept_valid [dsts_pkg::MaxKeep];
  rank_t                      pending_ranks [$];

  int errors = 0;
  int items_sent = 0;
  int sets_sent = 0;
  int ranks_seen = 0;
  int reg_writes = 0;
  bit random_phase = 1'b0;
  record_t directed [24];
  record_t rec, prev;

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] decayed_score(record_t r);
    logic [63:0] raw, age;
    raw = 64'(r.likes) * 30 + 64'(r.views) * 10 + 64'(r.cmts) * 20;
    age = (now_reg > r.created) ? 64'(now_reg - r.created) : 64'd0;
    if (age < 64'd3600) age = 64'd3600;
    return (raw * 64'd720 * 64'd65536) / (age + 64'd7200);
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < dsts_pkg::MaxKeep; i++) begin
      kept_score[i] = '0;
      kept_id[i] = '0;
      kept_valid[i] = 1'b0;
    end
  endfunction

  // Insert in score order; ties keep the earlier record ahead
  function automatic void insert_ranked(logic [63:0] score, logic [dsts_pkg::IdW-1:0] id);
    int pos;
    pos = 0;
    while (pos < dsts_pkg::MaxKeep && kept_valid[pos] && kept_score[pos] >= score) pos++;
    if (pos < dsts_pkg::MaxKeep) begin
      for (int i = dsts_pkg::MaxKeep - 1; i > pos; i--) begin
        kept_score[i] = kept_score[i-1];
        kept_id[i] = kept_id[i-1];
        kept_valid[i] = kept_valid[i-1];
      end
      kept_score[pos] = score;
      kept_id[pos] = id;
      kept_valid[pos] = 1'b1;
    end
  endfunction

  // Update the predictor with one accepted record
  function automatic void account_record(record_t r);
    int keep, count, base;
    rank_t e;
    base = pending_ranks.size();
    insert_ranked(decayed_score(r), r.id);
    if (r.fin) begin
      keep = (top_reg == 0) ? 1 : int'(top_reg);
      if (keep > dsts_pkg::MaxKeep) keep = dsts_pkg::MaxKeep;
      count = 0;
      while (count < keep && kept_valid[count]) count++;
      for (int k = 0; k < count; k++) begin
        e.id = kept_id[k];
        e.rank = dsts_pkg::RankW'(k);
        e.last = (k == count - 1);
        pending_ranks = {pending_ranks, e};
      end
      clear_store();
      if (r.typed) begin
        while (pending_ranks.size() > base) void'(pending_ranks.pop_back());
        e.id = r.typed_id;
        e.rank = '0;
        e.last = 1'b1;
        pending_ranks = {pending_ranks, e};
      end
    end
  endfunction

  // Offer one record after a random gap and wait for its transaction
  task automatic send_record(record_t r);
    int gap;
    gap = $urandom_range(0, 6);
    if (random_phase && ($urandom_range(0, 3) == 0)) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    record_id_i <= r.id;
    like_count_i <= r.likes;
    view_count_i <= r.views;
    comment_total_i <= r.cmts;
    created_time_i <= r.created;
    final_record_i <= r.fin;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    account_record(r);
    items_sent++;
    if (r.fin) sets_sent++;
  endtask

  // Let every result drain and the score unit settle before a register write
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_ranks.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [dsts_pkg::CfgIdxW-1:0] idx,
                           logic [dsts_pkg::TimeW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    if (idx == dsts_pkg::RegNowTime) now_reg = data;
    else if (idx == dsts_pkg::RegTopCount) top_reg = data[4:0];
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [dsts_pkg::CntW-1:0] rand_count();
    case ($urandom_range(0, 3))
      0: return dsts_pkg::CntW'($urandom);
      1: return dsts_pkg::CntW'($urandom_range(0, 1000));
      2: return '0;
      default: return dsts_pkg::CntW'($urandom_range(0, 50));
    endcase
  endfunction

  function automatic logic [dsts_pkg::TimeW-1:0] rand_created();
    case ($urandom_range(0, 3))
      0: return dsts_pkg::TimeW'({$urandom, $urandom});
      1: return now_reg + dsts_pkg::TimeW'($urandom_range(0, 5000));
      default: return now_reg - dsts_pkg::TimeW'($urandom_range(0, 2000000));
    endcase
  endfunction

  // Result side: random stalls, one long hold-off during the random part
  initial begin : rank_receiver
    int gap;
    rank_t want;
    bit held = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // long hold-off once, started while a result is waiting
      if (!held && random_phase && ranks_seen >= 20) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        do @(negedge clk_i); while (!out_valid_o);
        repeat (LongHold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      if (pending_ranks.size() == 0) begin
        report("unexpected rank, id", best_id_o, 0);
      end else begin
        want = pending_ranks.pop_front();
        if (best_id_o !== want.id) report("best_id", best_id_o, want.id);
        if (rank_o !== want.rank) report("rank", rank_o, want.rank);
        if (run_end_o !== want.last) report("run_end", run_end_o, want.last);
      end
      ranks_seen++;
      @(posedge clk_i);
    end
  end

  // Watchdog: cycles without any transaction
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= IdleLimit) begin
      $display("timeout: no transaction for %0d cycles", IdleLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int len, guard;
    now_reg = '0;
    top_reg = 5'd10;
    clear_store();

    // Directed table: row 0 runs at reset settings, the rest after setup
    directed[0] = '{31'd5, '0, '0, '0, '0, 1'b1, 1'b1, 31'd5};
    directed[1] = '{31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
                    40'd100000, 1'b0, 1'b0, '0};
    directed[2] = '{31'd0, '0, '0, '0, '0, 1'b0, 1'b0, '0};
    // future creation, then an equal score that must stay behind it
    directed[3] = '{31'd1, 31'd1, '0, '0, 40'hFFFFFFFFFF, 1'b0, 1'b0, '0};
    directed[4] = '{31'd2, 31'd1, '0, '0, 40'd100000, 1'b0, 1'b0, '0};
    directed[5] = '{31'd3, '0, 31'h7FFFFFFF, '0, 40'd0, 1'b0, 1'b0, '0};
    directed[6] = '{31'd4, '0, '0, 31'h7FFFFFFF, 40'd50000, 1'b0, 1'b0, '0};
    // fill past the store depth so low scores are dropped
    for (int k = 7; k < 20; k++)
      directed[k] = '{31'(k + 10), 31'(k), '0, '0, 40'd99000, k == 19, 1'b0, '0};
    // short sets for top count zero and top count above the depth
    directed[20] = '{31'd40, 31'd9, '0, '0, 40'd1, 1'b0, 1'b0, '0};
    directed[21] = '{31'd41, 31'd900, '0, '0, 40'd1, 1'b1, 1'b0, '0};
    directed[22] = '{31'd50, 31'd3, 31'd3, 31'd3, 40'd7, 1'b0, 1'b0, '0};
    directed[23] = '{31'd51, 31'd3, 31'd3, 31'd3, 40'd7, 1'b1, 1'b0, '0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_record(directed[0]);
    wait_idle();
    write_reg(dsts_pkg::RegNowTime, 40'd100000);
    write_reg(dsts_pkg::RegTopCount, 40'd16);
    for (int k = 1; k < 20; k++) send_record(directed[k]);
    wait_idle();
    write_reg(dsts_pkg::RegTopCount, 40'd0);
    write_reg(RegSpareLo, 40'hFFFFFFFFFF);
    write_reg(RegSpareHi, 40'd0);
    for (int k = 20; k < 22; k++) send_record(directed[k]);
    wait_idle();
    write_reg(dsts_pkg::RegTopCount, 40'hFFFFFFFFFF);
    write_reg(dsts_pkg::RegNowTime, 40'hFFFFFFFFFF);
    for (int k = 22; k < 24; k++) send_record(directed[k]);

    // Random sets, sometimes with new settings in between
    random_phase = 1'b1;
    prev = directed[23];
    while (items_sent < 120) begin
      if (sets_sent > 5 && $urandom_range(0, 2) == 0) begin
        wait_idle();
        write_reg(dsts_pkg::RegNowTime, dsts_pkg::TimeW'({$urandom, $urandom}));
        write_reg(dsts_pkg::RegTopCount, dsts_pkg::TimeW'($urandom_range(0, 31)));
        if ($urandom_range(0, 3) == 0)
          write_reg(($urandom_range(0, 1) == 0) ? RegSpareLo : RegSpareHi,
                    dsts_pkg::TimeW'({$urandom, $urandom}));
      end
      len = $urandom_range(1, 22);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 5) == 0) begin
          rec = prev;
          rec.id = dsts_pkg::IdW'($urandom);
        end else begin
          rec.id = dsts_pkg::IdW'($urandom);
          rec.likes = rand_count();
          rec.views = rand_count();
          rec.cmts = rand_count();
          rec.created = rand_created();
        end
        rec.fin = (k == len - 1);
        rec.typed = 1'b0;
        send_record(rec);
        prev = rec;
      end
    end

    // Drain and settle
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_ranks.size() > 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_ranks.size() > 0) report("ranks never reported", pending_ranks.size(), 0);
    $display("covered %0d records in %0d sets, %0d ranks checked, %0d register writes",
             items_sent, sets_sent, ranks_seen, reg_writes);
    $display("including ties, future creation, full store, top count 0 and 31");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+src
src/dsts_pkg.sv
src/dsts_score_div.sv
src/dsts_cell.sv
src/decayed_score_top_n_select.sv
src/dsts_checker.sv
tb/decayed_score_top_n_select_test.sv
